[rtl/atan2_pkg.sv]
// ----------------------------------------------------------------------------
// atan2 package
// Shared widths, fixed-point constants and the per-stage cell payload type.
// ----------------------------------------------------------------------------
package atan2_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

    // Magnitudes of num and den; den fits in COORD_WIDTH+1 bits unsigned.
    localparam int MAG_WIDTH  = COORD_WIDTH + 1;
    // Quotient m = round(n*2^15/den), range 0..32768.
    localparam int Q_BITS     = 17;
    // Dividend n<<16 | den, divided by den<<1.
    localparam int DVD_WIDTH  = MAG_WIDTH + 17;
    localparam int DIV_CELLS  = Q_BITS;

    localparam logic [31:0] C3_Q32  = 32'd843102080;
    localparam logic [31:0] C1_Q32  = 32'd4216369394;
    localparam logic [34:0] QPI_Q32 = 35'd3373259426;
    localparam logic [34:0] TQPI_Q32 = 35'd10119778278;

    localparam int SUM_SHIFT = 47 - ANGLE_FRAC_BITS;
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_LIMIT =
        ANGLE_WIDTH'((64'd13493037704 + (64'd1 << (31 - ANGLE_FRAC_BITS)))
                     >> (32 - ANGLE_FRAC_BITS));

    // Context carried alongside each division cell.
    typedef struct packed {
        logic                 zero;
        logic                 y_neg;
        logic                 x_neg;
        logic                 r_pos;
    } ctx_t;

    typedef struct packed {
        logic                 valid;
        ctx_t                 ctx;
        logic [DVD_WIDTH-1:0] rem;
        logic [MAG_WIDTH:0]   dvs;   // den << 1
        logic [Q_BITS-1:0]    quo;
    } cell_t;

endpackage

[rtl/atan2_div_cell.sv]
// ----------------------------------------------------------------------------
// atan2 divider cell
// One restoring-division step: resolve one quotient bit and pass on.
// ----------------------------------------------------------------------------
module atan2_div_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic [4:0]      bit_pos,
    input  atan2_pkg::cell_t cell_in,
    output atan2_pkg::cell_t cell_out
);
    import atan2_pkg::*;

    logic                 valid_reg;
    ctx_t                 ctx_reg;
    logic [DVD_WIDTH-1:0] rem_reg;
    logic [MAG_WIDTH:0]   dvs_reg;
    logic [Q_BITS-1:0]    quo_reg;
    cell_t cell_next;
    logic [DVD_WIDTH+Q_BITS-1:0] trial;
    logic [DVD_WIDTH+Q_BITS-1:0] shifted_dvs;

    always_comb
    begin
        cell_next   = cell_in;
        shifted_dvs = (DVD_WIDTH+Q_BITS)'(cell_in.dvs) << bit_pos;
        trial       = (DVD_WIDTH+Q_BITS)'(cell_in.rem);
        if (trial >= shifted_dvs)
        begin
            cell_next.rem = DVD_WIDTH'(trial - shifted_dvs);
            cell_next.quo = cell_in.quo | (Q_BITS'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= cell_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg <= cell_next.ctx;
            rem_reg <= cell_next.rem;
            dvs_reg <= cell_next.dvs;
            quo_reg <= cell_next.quo;
        end
    end

    assign cell_out = {valid_reg, ctx_reg, rem_reg, dvs_reg, quo_reg};

endmodule

[rtl/atan2_poly.sv]
// ----------------------------------------------------------------------------
// atan2 polynomial
// Evaluate 0.1963*m^3 - 0.9817*m around the octant base, round, sign, clamp.
// ----------------------------------------------------------------------------
module atan2_poly (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  atan2_pkg::ctx_t                   in_ctx,
    input  logic [atan2_pkg::Q_BITS-1:0]      in_m,
    output logic                              out_valid,
    output logic signed [atan2_pkg::ANGLE_WIDTH-1:0] out_angle
);
    import atan2_pkg::*;

    // stage 1: m*m
    logic              v1_reg;
    ctx_t              c1_reg;
    logic [Q_BITS-1:0] m1_reg;
    logic [33:0]       sq_reg;
    // stage 2: C3*m^2
    logic              v2_reg;
    ctx_t              c2_reg;
    logic [Q_BITS-1:0] m2_reg;
    logic [65:0]       p2_reg;
    // stage 3: d = (C1-a)*m
    logic              v3_reg;
    ctx_t              c3_reg;
    logic [63:0]       d3_reg;
    // stage 4: output
    logic              v4_reg;
    logic signed [ANGLE_WIDTH-1:0] ang4_reg;

    logic [35:0] a_val;
    logic [31:0] ca_val;
    logic signed [65:0] sum_val;
    logic [65:0] mag_val;
    logic [65:0] rnd_val;
    logic signed [ANGLE_WIDTH+1:0] ang_val;
    logic signed [ANGLE_WIDTH+1:0] lim_ext;
    logic signed [ANGLE_WIDTH-1:0] ang_next;

    always_comb
    begin
        a_val   = 36'((p2_reg + (66'd1 << 29)) >> 30);
        ca_val  = 32'({4'd0, C1_Q32} - a_val);
        sum_val = c3_reg.x_neg ? $signed({16'd0, TQPI_Q32, 15'd0})
                               : $signed({16'd0, QPI_Q32, 15'd0});
        if (c3_reg.r_pos)
            sum_val = sum_val - $signed({2'd0, d3_reg});
        else
            sum_val = sum_val + $signed({2'd0, d3_reg});
        mag_val = sum_val[65] ? 66'(-sum_val) : 66'(sum_val);
        rnd_val = (mag_val + (66'd1 << (SUM_SHIFT - 1))) >> SUM_SHIFT;
        ang_val = sum_val[65] ? -$signed((ANGLE_WIDTH+2)'(rnd_val))
                              : $signed((ANGLE_WIDTH+2)'(rnd_val));
        if (c3_reg.y_neg)
            ang_val = -ang_val;
        lim_ext = (ANGLE_WIDTH+2)'(ANGLE_LIMIT);
        if (ang_val > lim_ext)
            ang_next = ANGLE_LIMIT;
        else if (ang_val < -lim_ext)
            ang_next = -ANGLE_LIMIT;
        else
            ang_next = ANGLE_WIDTH'(ang_val);
        if (c3_reg.zero)
            ang_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= in_ctx;
            m1_reg   <= in_m;
            sq_reg   <= in_m * in_m;
            c2_reg   <= c1_reg;
            m2_reg   <= m1_reg;
            p2_reg   <= 66'(sq_reg) * 66'(C3_Q32);
            c3_reg   <= c2_reg;
            d3_reg   <= 64'(ca_val) * 64'(m2_reg);
            ang4_reg <= ang_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_angle = ang4_reg;

endmodule

[rtl/atan2_polynomial_approx_top.sv]
// ----------------------------------------------------------------------------
// atan2 polynomial approximation, top level
// Octant reduction, chain of division cells, cubic polynomial, output register.
// ----------------------------------------------------------------------------
// Stages from accepted request to result valid: 1 prep, 17 divide cells,
//   4 polynomial stages, plus the output register stage.
// Throughput: one request per cycle; the divider is a row of 17 cells, one
//   quotient bit per cell, and the whole chain advances when the output is free.
// Reset: rst_n clears all valid bits asynchronously; payloads are not reset.
module atan2_polynomial_approx_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [atan2_pkg::COORD_WIDTH-1:0] y_value,
    input  logic signed [atan2_pkg::COORD_WIDTH-1:0] x_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [atan2_pkg::ANGLE_WIDTH-1:0] angle
);
    import atan2_pkg::*;

    // The pipeline moves as a whole; hold everything while the output
    // register is full and stalled.
    logic adv;
    logic fin_valid;
    logic signed [ANGLE_WIDTH-1:0] fin_angle;
    logic ov_reg;
    logic signed [ANGLE_WIDTH-1:0] ang_reg;

    assign adv      = !(ov_reg && out_stall);
    assign in_stall = !adv;

    // Octant reduction: form num, den and the context bits.
    logic signed [COORD_WIDTH:0] ys;
    logic signed [COORD_WIDTH:0] xs;
    logic signed [COORD_WIDTH:0] ay;
    logic signed [COORD_WIDTH+1:0] num;
    logic [MAG_WIDTH-1:0] n_mag;
    logic [MAG_WIDTH-1:0] den;
    cell_t prep;

    always_comb
    begin
        ys = COORD_WIDTH'(y_value) == 0 ? '0 : (COORD_WIDTH+1)'(y_value);
        xs = (COORD_WIDTH+1)'(x_value);
        ay = ys[COORD_WIDTH] ? -ys : ys;
        if (!xs[COORD_WIDTH])
        begin
            num = (COORD_WIDTH+2)'(xs) - (COORD_WIDTH+2)'(ay);
            den = MAG_WIDTH'(xs + ay);
        end
        else
        begin
            num = (COORD_WIDTH+2)'(xs) + (COORD_WIDTH+2)'(ay);
            den = MAG_WIDTH'(ay - xs);
        end
        n_mag = num[COORD_WIDTH+1] ? MAG_WIDTH'(-num) : MAG_WIDTH'(num);
        prep.valid      = in_valid;
        prep.ctx.zero   = (x_value == 0) && (y_value == 0);
        prep.ctx.y_neg  = y_value[COORD_WIDTH-1];
        prep.ctx.x_neg  = x_value[COORD_WIDTH-1];
        prep.ctx.r_pos  = !num[COORD_WIDTH+1] && (num != 0);
        prep.rem        = (DVD_WIDTH'(n_mag) << 16) + DVD_WIDTH'(den);
        prep.dvs        = (MAG_WIDTH+1)'(den) << 1;
        prep.quo        = '0;
        // Force a nonzero divisor for the both-zero case; the result is overridden.
        if (prep.ctx.zero)
            prep.dvs = (MAG_WIDTH+1)'(2);
    end

    // Register the prepared request, then walk it down the divider cells,
    // most significant quotient bit first.
    cell_t chain [DIV_CELLS+1];
    logic                 prep_valid_reg;
    ctx_t                 prep_ctx_reg;
    logic [DVD_WIDTH-1:0] prep_rem_reg;
    logic [MAG_WIDTH:0]   prep_dvs_reg;
    logic [Q_BITS-1:0]    prep_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (adv)
            prep_valid_reg <= prep.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_ctx_reg <= prep.ctx;
            prep_rem_reg <= prep.rem;
            prep_dvs_reg <= prep.dvs;
            prep_quo_reg <= prep.quo;
        end
    end

    assign chain[0] = {prep_valid_reg, prep_ctx_reg, prep_rem_reg, prep_dvs_reg, prep_quo_reg};

    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        atan2_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .bit_pos  (5'(DIV_CELLS - 1 - i)),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Polynomial and final rounding.
    atan2_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (chain[DIV_CELLS].valid),
        .in_ctx    (chain[DIV_CELLS].ctx),
        .in_m      (chain[DIV_CELLS].quo),
        .out_valid (fin_valid),
        .out_angle (fin_angle)
    );

    // Output register: load when free, hold while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= fin_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ang_reg <= fin_angle;
    end

    assign out_valid = ov_reg;
    assign angle     = ang_reg;

endmodule

[rtl/atan2_checker.sv]
// ----------------------------------------------------------------------------
// atan2 port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module atan2_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [atan2_pkg::ANGLE_WIDTH-1:0] angle
);
    import atan2_pkg::*;

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angle <= ANGLE_LIMIT && angle >= -ANGLE_LIMIT))
        else $error("angle out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("stalled result changed");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind atan2_polynomial_approx_top atan2_checker u_atan2_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
);
